// ===== rtl/monte_carlo_option_payoff_top_defines.svh =====
// assertion macros
`ifndef MONTE_CARLO_OPTION_PAYOFF_TOP_DEFINES_SVH
`define MONTE_CARLO_OPTION_PAYOFF_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MCOP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");
`define MCOP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`else
`define MCOP_ASSERT_IMP(label, clk, rst, a, b)
`define MCOP_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/mcop_pkg.sv =====
package mcop_pkg;

  localparam logic [3:0] REG_PAYOFF_MODE    = 4'd0;
  localparam logic [3:0] REG_STEPS_PER_PATH = 4'd1;
  localparam logic [3:0] REG_DRIFT_STEP     = 4'd2;
  localparam logic [3:0] REG_DIFFUSION_STEP = 4'd3;
  localparam logic [3:0] REG_SPOT_PRICE     = 4'd4;
  localparam logic [3:0] REG_STRIKE_PRICE   = 4'd5;
  localparam logic [3:0] REG_BARRIER_LEVEL  = 4'd6;
  localparam logic [3:0] REG_DISCOUNT       = 4'd7;

  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [31:0] EXP_COEF_5 = 32'd165394;
  localparam logic [31:0] LOG_MAX    = 32'h7FFF_FFFF;
  localparam logic [51:0] TOTAL_MAX  = {52{1'b1}};

  typedef struct packed {
    logic [31:0] log_return;
    logic [31:0] min_log_return;
    logic        last;
  } entry_t;

  function automatic logic [31:0] exp_coef(input logic [2:0] i);
    logic [31:0] c;
    case (i)
      3'd0: c = 32'd1431680;
      3'd1: c = 32'd10327388;
      3'd2: c = 32'd59597083;
      3'd3: c = 32'd257941248;
      3'd4: c = 32'd744261118;
      default: c = 32'd1073741824;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mcop_in_if.sv =====
interface mcop_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_sample;
  logic               end_of_run;
  modport source(output valid, normal_sample, end_of_run, input ready);
  modport sink(input valid, normal_sample, end_of_run, output ready);
endinterface

// ===== rtl/mcop_out_if.sv =====
interface mcop_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] path_payout;
  logic        knocked_in;
  logic        price_valid;
  logic [31:0] price_estimate;
  logic [20:0] paths_in_run;
  modport source(output valid, path_payout, knocked_in, price_valid, price_estimate,
                 paths_in_run, input ready);
  modport sink(input valid, path_payout, knocked_in, price_valid, price_estimate,
               paths_in_run, output ready);
endinterface

// ===== rtl/mcop_cfg_if.sv =====
interface mcop_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/mcop_queue.sv =====
module mcop_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mcop_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mcop_pkg::entry_t pop_data
);

  mcop_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/mcop_front.sv =====
module mcop_front #(
  parameter int MAX_STEPS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  mcop_in_if.sink          samples,
  input  logic [10:0]      steps_per_path,
  input  logic [31:0]      drift_step,
  input  logic [30:0]      diffusion_step,
  input  logic             q_full,
  output logic             q_push,
  output mcop_pkg::entry_t q_data
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int CW = (SW > 11) ? SW : 11;

  logic               busy;
  logic               last_r;
  logic signed [47:0] term_prod;
  logic signed [31:0] log_return;
  logic signed [31:0] min_log_return;
  logic [SW-1:0]      step_index;

  logic [CW-1:0]      steps_ext;
  logic [CW-1:0]      eff_steps;
  logic signed [34:0] sum;
  logic signed [31:0] log_next;
  logic signed [31:0] min_next;
  logic               path_done;

  assign samples.ready = !busy && !q_full;

  always_comb begin
    steps_ext = CW'(steps_per_path);
    if (steps_per_path == 11'd0) begin
      eff_steps = CW'(1);
    end else if (steps_ext > CW'(MAX_STEPS)) begin
      eff_steps = CW'(MAX_STEPS);
    end else begin
      eff_steps = steps_ext;
    end
    sum = 35'(log_return) + 35'($signed(drift_step)) + 35'(term_prod >>> 14);
    if (sum > 35'sh0_7FFF_FFFF) begin
      log_next = 32'sh7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      log_next = 32'sh8000_0000;
    end else begin
      log_next = sum[31:0];
    end
    min_next  = (log_next < min_log_return) ? log_next : min_log_return;
    path_done = !((CW'(step_index) + CW'(1)) < eff_steps);
  end

  assign q_push = busy && path_done;
  assign q_data = '{log_return: log_next, min_log_return: min_next, last: last_r};

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      term_prod <= $signed({1'b0, diffusion_step}) * samples.normal_sample;
      last_r    <= samples.end_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      log_return     <= '0;
      min_log_return <= mcop_pkg::LOG_MAX;
      step_index     <= '0;
    end else if (busy) begin
      busy <= 1'b0;
      if (path_done) begin
        log_return     <= '0;
        min_log_return <= mcop_pkg::LOG_MAX;
        step_index     <= '0;
      end else begin
        log_return     <= log_next;
        min_log_return <= min_next;
        step_index     <= step_index + SW'(1);
      end
    end else if (samples.valid && samples.ready) begin
      busy <= 1'b1;
    end
  end

endmodule

// ===== rtl/mcop_back.sv =====
module mcop_back #(
  parameter int MAX_PATHS = 1048576
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  mcop_pkg::entry_t q_data,
  output logic             q_pop,
  input  logic [1:0]       payoff_mode,
  input  logic [31:0]      spot_price,
  input  logic [31:0]      strike_price,
  input  logic [31:0]      barrier_log_level,
  input  logic [16:0]      discount_factor,
  mcop_out_if.source       results
);

  localparam int PW = $clog2(MAX_PATHS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOG   = 4'd1;
  localparam logic [3:0] S_POLY  = 4'd2;
  localparam logic [3:0] S_PRICE = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_PAY   = 4'd5;
  localparam logic [3:0] S_DISC  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]         state;
  logic signed [31:0] x;
  logic signed [31:0] mn;
  logic               last_r;
  logic signed [33:0] y;
  logic [31:0]        acc;
  logic [2:0]         iter;
  logic [63:0]        prod;
  logic [31:0]        price;
  logic [31:0]        payoff;
  logic               knocked;
  logic [31:0]        payout;
  logic [51:0]        total;
  logic [PW-1:0]      pidx;
  logic [PW:0]        rem;
  logic [51:0]        quo;
  logic [5:0]         dcnt;

  logic               out_valid;
  logic [31:0]        out_payout;
  logic               out_knocked;
  logic               out_last;
  logic [31:0]        out_est;
  logic [20:0]        out_paths;

  logic signed [63:0] y_full;
  logic [29:0]        f;
  logic signed [9:0]  s;
  logic [9:0]         n;
  logic [61:0]        acc_prod;
  logic [63:0]        shr;
  logic [63:0]        shl;
  logic [31:0]        price_next;
  logic [48:0]        disc_prod;
  logic [52:0]        tsum;
  logic [51:0]        total_next;
  logic [PW-1:0]      pidx_next;
  logic [PW:0]        rem_sh;
  logic [PW:0]        rem_next;
  logic [51:0]        quo_next;

  always_comb begin
    y_full   = x * $signed({1'b0, mcop_pkg::LOG2E_Q30});
    f        = {y[25:0], 4'b0000};
    s        = 10'sd30 - 10'($signed(y[33:26]));
    n        = 10'd0 - 10'(s);
    acc_prod = acc * f;
    shr      = prod >> s[5:0];
    shl      = {32'd0, prod[31:0]} << n[4:0];
    if (s >= 10'sd64) begin
      price_next = 32'd0;
    end else if (s >= 10'sd0) begin
      price_next = (shr[63:32] != 32'd0) ? 32'hFFFF_FFFF : shr[31:0];
    end else if (prod == 64'd0) begin
      price_next = 32'd0;
    end else if (n >= 10'd32 || prod[63:32] != 32'd0 || shl[63:32] != 32'd0) begin
      price_next = 32'hFFFF_FFFF;
    end else begin
      price_next = shl[31:0];
    end
    disc_prod  = payoff * discount_factor;
    tsum       = {1'b0, total} + 53'(payout);
    total_next = tsum[52] ? mcop_pkg::TOTAL_MAX : tsum[51:0];
    pidx_next  = (PW'(MAX_PATHS) > pidx) ? pidx + PW'(1) : pidx;
    rem_sh     = {rem[PW-1:0], quo[51]};
    if (rem_sh >= {1'b0, pidx}) begin
      rem_next = rem_sh - {1'b0, pidx};
      quo_next = {quo[50:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      quo_next = {quo[50:0], 1'b0};
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  assign results.valid          = out_valid;
  assign results.path_payout    = out_payout;
  assign results.knocked_in     = out_knocked;
  assign results.price_valid    = out_last;
  assign results.price_estimate = out_est;
  assign results.paths_in_run   = out_paths;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x      <= q_data.log_return;
        mn     <= q_data.min_log_return;
        last_r <= q_data.last;
      end
      S_LOG: begin
        y    <= y_full[63:30];
        acc  <= mcop_pkg::EXP_COEF_5;
        iter <= 3'd0;
      end
      S_POLY: begin
        acc  <= mcop_pkg::exp_coef(iter) + acc_prod[61:30];
        iter <= iter + 3'd1;
      end
      S_PRICE: prod <= spot_price * acc;
      S_SCALE: price <= price_next;
      S_PAY: begin
        if (payoff_mode[0]) begin
          payoff <= (price < strike_price) ? strike_price - price : 32'd0;
        end else begin
          payoff <= (price > strike_price) ? price - strike_price : 32'd0;
        end
        knocked <= !payoff_mode[1] || (mn <= $signed(barrier_log_level));
      end
      S_DISC: begin
        if (!knocked) begin
          payout <= 32'd0;
        end else begin
          payout <= disc_prod[48] ? 32'hFFFF_FFFF : disc_prod[47:16];
        end
      end
      S_ACC: begin
        rem         <= '0;
        quo         <= total_next;
        dcnt        <= 6'd0;
        out_payout  <= payout;
        out_knocked <= knocked;
        out_last    <= last_r;
        out_paths   <= 21'(pidx_next);
        out_est     <= 32'd0;
      end
      S_DIV: begin
        rem  <= rem_next;
        quo  <= quo_next;
        dcnt <= dcnt + 6'd1;
        out_est <= (quo_next[51:32] != 20'd0) ? 32'hFFFF_FFFF : quo_next[31:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_LOG;
          end
        end
        S_LOG: state <= S_POLY;
        S_POLY: begin
          if (iter == 3'd5) begin
            state <= S_PRICE;
          end
        end
        S_PRICE: state <= S_SCALE;
        S_SCALE: state <= S_PAY;
        S_PAY:   state <= S_DISC;
        S_DISC:  state <= S_ACC;
        S_ACC: begin
          total <= total_next;
          pidx  <= pidx_next;
          if (last_r) begin
            state <= S_DIV;
          end else begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_DIV: begin
          if (dcnt == 6'd51) begin
            total     <= '0;
            pidx      <= '0;
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/monte_carlo_option_payoff_top.sv =====
// Step accumulator: each sample's diffusion product is registered, then added to the path's log
// return; no new sample is taken until then or while the queue is full. Payoff unit (exp
// polynomial, scale, discount, and a division when closing a run) takes one path at a time and
// the next only once its result is accepted; a two-entry queue lets sampling continue while
// the payoff unit works.
// Reset (rst, synchronous): config registers to defaults, path state and run totals cleared.
`include "monte_carlo_option_payoff_top_defines.svh"

module monte_carlo_option_payoff_top #(
  parameter int MAX_STEPS = 1024,
  parameter int MAX_PATHS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  mcop_in_if.sink     samples,
  mcop_out_if.source  results,
  mcop_cfg_if.sink    cfg
);

  logic [1:0]  payoff_mode;
  logic [10:0] steps_per_path;
  logic [31:0] drift_step;
  logic [30:0] diffusion_step;
  logic [31:0] spot_price;
  logic [31:0] strike_price;
  logic [31:0] barrier_log_level;
  logic [16:0] discount_factor;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  mcop_pkg::entry_t q_in;
  mcop_pkg::entry_t q_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payoff_mode       <= 2'd0;
      steps_per_path    <= 11'd1;
      drift_step        <= 32'd0;
      diffusion_step    <= 31'd0;
      spot_price        <= 32'd6553600;
      strike_price      <= 32'd7208960;
      barrier_log_level <= 32'd0;
      discount_factor   <= 17'd65536;
    end else if (cfg.valid) begin
      case (cfg.index)
        mcop_pkg::REG_PAYOFF_MODE:    payoff_mode       <= cfg.data[1:0];
        mcop_pkg::REG_STEPS_PER_PATH: steps_per_path    <= cfg.data[10:0];
        mcop_pkg::REG_DRIFT_STEP:     drift_step        <= cfg.data;
        mcop_pkg::REG_DIFFUSION_STEP: diffusion_step    <= cfg.data[30:0];
        mcop_pkg::REG_SPOT_PRICE:     spot_price        <= cfg.data;
        mcop_pkg::REG_STRIKE_PRICE:   strike_price      <= cfg.data;
        mcop_pkg::REG_BARRIER_LEVEL:  barrier_log_level <= cfg.data;
        mcop_pkg::REG_DISCOUNT:       discount_factor   <= cfg.data[16:0];
        default: begin
        end
      endcase
    end
  end

  mcop_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .samples        (samples),
    .steps_per_path (steps_per_path),
    .drift_step     (drift_step),
    .diffusion_step (diffusion_step),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  mcop_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  mcop_back #(.MAX_PATHS(MAX_PATHS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_out),
    .q_pop             (q_pop),
    .payoff_mode       (payoff_mode),
    .spot_price        (spot_price),
    .strike_price      (strike_price),
    .barrier_log_level (barrier_log_level),
    .discount_factor   (discount_factor),
    .results           (results)
  );

  `MCOP_ASSERT_IMP(a_no_push_when_full, clk, rst, q_push, !q_full)
  `MCOP_ASSERT_IMP(a_est_only_on_last, clk, rst, results.valid && !results.price_valid, results.price_estimate == 32'd0)
  `MCOP_ASSERT_IMP(a_no_payout_unless_in, clk, rst, results.valid && !results.knocked_in, results.path_payout == 32'd0)

endmodule

// ===== test/monte_carlo_option_payoff_top_tb.sv =====
`timescale 1ns / 1ps

module monte_carlo_option_payoff_top_tb;

  localparam int        STEP_CAP    = 1024;
  localparam int        PATH_CAP    = 1048576;
  localparam int        CYCLE_LIMIT = 2000000;
  localparam int        HOLD_CYCLES = 600;
  localparam logic [3:0] REG_SPARE  = 4'd9;
  localparam logic [63:0] POLY [6] = '{64'd744261118, 64'd257941248, 64'd59597083,
                                       64'd10327388, 64'd1431680, 64'd165394};
  localparam logic [63:0] LOG2E     = 64'd1549082005;
  localparam logic [51:0] TOTAL_TOP = {52{1'b1}};

  typedef enum int {CFG_TYPICAL, CFG_HIGH, CFG_LOW} cfg_kind_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               eor;
  } sample_t;

  typedef struct {
    logic [31:0] payout;
    logic        knocked;
    logic        price_valid;
    logic [31:0] estimate;
    logic [20:0] paths;
  } payout_t;

  logic clk;
  logic rst;

  mcop_in_if  in_if ();
  mcop_out_if out_if ();
  mcop_cfg_if cfg_if ();

  monte_carlo_option_payoff_top DUT (
    .clk(clk),
    .rst(rst),
    .samples(in_if),
    .results(out_if),
    .cfg(cfg_if)
  );

  // pricing state mirrored from the block
  logic [1:0]         m_mode;
  logic [10:0]        m_steps;
  logic signed [31:0] m_drift;
  logic [30:0]        m_diff;
  logic [31:0]        m_spot;
  logic [31:0]        m_strike;
  logic signed [31:0] m_barrier;
  logic [16:0]        m_disc;
  logic signed [31:0] log_ret;
  logic signed [31:0] min_log;
  int unsigned        step_idx;
  logic [51:0]        payout_sum;
  int unsigned        path_cnt;

  sample_t pending_samples[$];
  payout_t expected_payouts[$];
  int      send_idle;
  int      recv_stall;
  bit      in_taken;
  bit      hold_req;
  bit      hold_done;
  int      hold_left;
  int      cycles;
  int      errors;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] terminal_price(input logic signed [31:0] x,
                                                 input logic [31:0] spot);
    longint      y;
    longint      k;
    longint      s;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] prod;
    y = (longint'(x) * longint'(LOG2E)) >>> 30;
    k = y >>> 26;
    f = 64'(y[25:0]) << 4;
    acc = POLY[5];
    for (int i = 4; i >= 0; i--) acc = POLY[i] + ((acc * f) >> 30);
    acc = (64'd1 << 30) + ((acc * f) >> 30);
    prod = 64'(spot) * acc;
    s = 30 - k;
    if (s >= 64) return 32'd0;
    if (s >= 0) return sat32(prod >> s);
    if (prod == 64'd0) return 32'd0;
    if (-s >= 32 || prod > (64'hFFFF_FFFF >> (-s))) return 32'hFFFF_FFFF;
    return 32'(prod << (-s));
  endfunction

  task automatic reset_pricing();
    m_mode = 2'd0;
    m_steps = 11'd1;
    m_drift = '0;
    m_diff = '0;
    m_spot = 32'd6553600;
    m_strike = 32'd7208960;
    m_barrier = '0;
    m_disc = 17'd65536;
    log_ret = '0;
    min_log = mcop_pkg::LOG_MAX;
    step_idx = 0;
    payout_sum = '0;
    path_cnt = 0;
  endtask

  task automatic apply_reg(input logic [3:0] idx, input logic [31:0] d);
    case (idx)
      mcop_pkg::REG_PAYOFF_MODE:    m_mode = d[1:0];
      mcop_pkg::REG_STEPS_PER_PATH: m_steps = d[10:0];
      mcop_pkg::REG_DRIFT_STEP:     m_drift = d;
      mcop_pkg::REG_DIFFUSION_STEP: m_diff = d[30:0];
      mcop_pkg::REG_SPOT_PRICE:     m_spot = d;
      mcop_pkg::REG_STRIKE_PRICE:   m_strike = d;
      mcop_pkg::REG_BARRIER_LEVEL:  m_barrier = d;
      mcop_pkg::REG_DISCOUNT:       m_disc = d[16:0];
      default: ;
    endcase
  endtask

  task automatic price_sample(input sample_t it);
    int unsigned eff;
    longint      sum;
    logic [31:0] price;
    logic [31:0] payoff;
    payout_t     r;
    eff = (m_steps == 0) ? 1 : (m_steps > STEP_CAP) ? STEP_CAP : m_steps;
    sum = longint'(log_ret) + longint'(m_drift) +
          ((longint'(m_diff) * longint'(it.sample)) >>> 14);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    log_ret = sum[31:0];
    if (log_ret < min_log) min_log = log_ret;
    if (step_idx + 1 < eff) begin
      step_idx++;
      return;
    end
    price = terminal_price(log_ret, m_spot);
    if (m_mode[0]) payoff = (price < m_strike) ? m_strike - price : 32'd0;
    else payoff = (price > m_strike) ? price - m_strike : 32'd0;
    r.knocked = !m_mode[1] || (min_log <= m_barrier);
    r.payout = r.knocked ? sat32((64'(payoff) * 64'(m_disc)) >> 16) : 32'd0;
    if (53'(payout_sum) + 53'(r.payout) > 53'(TOTAL_TOP)) payout_sum = TOTAL_TOP;
    else payout_sum = payout_sum + 52'(r.payout);
    if (path_cnt < PATH_CAP) path_cnt++;
    r.price_valid = it.eor;
    r.paths = path_cnt[20:0];
    r.estimate = '0;
    if (it.eor) begin
      r.estimate = sat32(64'(payout_sum) / 64'(path_cnt));
      payout_sum = '0;
      path_cnt = 0;
    end
    expected_payouts.push_back(r);
    log_ret = '0;
    min_log = mcop_pkg::LOG_MAX;
    step_idx = 0;
  endtask

  always @(posedge clk) begin
    in_taken <= in_if.valid && in_if.ready;
    if (!rst && cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
    if (!rst && in_if.valid && in_if.ready)
      price_sample('{sample: in_if.normal_sample, eor: in_if.end_of_run});
  end

  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_samples.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
        in_if.valid <= 1'b1;
        in_if.normal_sample <= pending_samples[0].sample;
        in_if.end_of_run <= pending_samples[0].eor;
        void'(pending_samples.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    payout_t e;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_payouts.size() == 0) begin
        $display("%0t: unexpected transaction, payout %h", $time, out_if.path_payout);
        errors++;
      end else begin
        e = expected_payouts.pop_front();
        if (out_if.path_payout !== e.payout) begin
          $display("%0t: path_payout expected %h actual %h", $time, e.payout,
                   out_if.path_payout);
          errors++;
        end
        if (out_if.knocked_in !== e.knocked) begin
          $display("%0t: knocked_in expected %b actual %b", $time, e.knocked,
                   out_if.knocked_in);
          errors++;
        end
        if (out_if.price_valid !== e.price_valid) begin
          $display("%0t: price_valid expected %b actual %b", $time, e.price_valid,
                   out_if.price_valid);
          errors++;
        end
        if (out_if.price_estimate !== e.estimate) begin
          $display("%0t: price_estimate expected %h actual %h", $time, e.estimate,
                   out_if.price_estimate);
          errors++;
        end
        if (out_if.paths_in_run !== e.paths) begin
          $display("%0t: paths_in_run expected %0d actual %0d", $time, e.paths,
                   out_if.paths_in_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // keep the low bits that matter, fill the rest with noise
  function automatic logic [31:0] noisy(input logic [31:0] v, input int w);
    logic [31:0] m;
    m = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    return ($urandom & ~m) | (v & m);
  endfunction

  task automatic push(input logic signed [15:0] s, input logic eor);
    pending_samples.push_back('{sample: s, eor: eor});
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_samples.size() > 0 || in_if.valid || expected_payouts.size() > 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3, 0))
      0: return 16'($urandom);
      1: return $urandom_range(1, 0) ? 16'sh7FFF : -16'sh8000;
      default: return 16'($signed($urandom_range(16384, 0)) - 8192);
    endcase
  endfunction

  task automatic setup(input cfg_kind_t kind);
    logic [10:0] steps;
    steps = ($urandom_range(9, 0) == 0) ? 11'($urandom_range(40, 9))
                                        : 11'($urandom_range(6, 0));
    write_reg(mcop_pkg::REG_PAYOFF_MODE, noisy(32'($urandom_range(3, 0)), 2));
    write_reg(mcop_pkg::REG_STEPS_PER_PATH, noisy(32'(steps), 11));
    case (kind)
      CFG_HIGH: begin
        write_reg(mcop_pkg::REG_DRIFT_STEP, 32'h7FFF_FFFF);
        write_reg(mcop_pkg::REG_DIFFUSION_STEP, 32'h7FFF_FFFF);
        write_reg(mcop_pkg::REG_SPOT_PRICE, 32'hFFFF_FFFF);
        write_reg(mcop_pkg::REG_STRIKE_PRICE, 32'h0000_0000);
        write_reg(mcop_pkg::REG_BARRIER_LEVEL, 32'h7FFF_FFFF);
        write_reg(mcop_pkg::REG_DISCOUNT, 32'h0001_FFFF);
      end
      CFG_LOW: begin
        write_reg(mcop_pkg::REG_DRIFT_STEP, 32'h8000_0000);
        write_reg(mcop_pkg::REG_DIFFUSION_STEP, 32'h0000_0000);
        write_reg(mcop_pkg::REG_SPOT_PRICE, 32'h0000_0000);
        write_reg(mcop_pkg::REG_STRIKE_PRICE, 32'hFFFF_FFFF);
        write_reg(mcop_pkg::REG_BARRIER_LEVEL, 32'h8000_0000);
        write_reg(mcop_pkg::REG_DISCOUNT, 32'h0000_0000);
      end
      default: begin
        write_reg(mcop_pkg::REG_DRIFT_STEP,
                  32'($signed($urandom_range(4000000, 0)) - 2000000));
        write_reg(mcop_pkg::REG_DIFFUSION_STEP, noisy(32'($urandom_range(1 << 27, 0)), 31));
        write_reg(mcop_pkg::REG_SPOT_PRICE, 32'($urandom_range(200 << 16, 1 << 16)));
        write_reg(mcop_pkg::REG_STRIKE_PRICE, 32'($urandom_range(200 << 16, 1 << 16)));
        write_reg(mcop_pkg::REG_BARRIER_LEVEL, -32'($urandom_range(1 << 26, 0)));
        write_reg(mcop_pkg::REG_DISCOUNT, noisy(32'($urandom_range(65536, 50000)), 17));
      end
    endcase
  endtask

  initial begin
    int idle_sets [4][2];
    int count;
    idle_sets = '{'{0, 0}, '{63, 0}, '{0, 63}, '{38, 38}};
    errors = 0;
    cycles = 0;
    hold_req = 0;
    hold_done = 0;
    hold_left = 0;
    send_idle = 0;
    recv_stall = 0;
    in_taken = 0;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.normal_sample = '0;
    in_if.end_of_run = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    reset_pricing();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // european call and put, one step per path
    write_reg(mcop_pkg::REG_DIFFUSION_STEP, 32'd53687091);
    write_reg(mcop_pkg::REG_STRIKE_PRICE, 32'd6553600);
    write_reg(mcop_pkg::REG_DISCOUNT, 32'd62259);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    push(16'sh7FFF, 1'b0);
    push(-16'sh8000, 1'b0);
    push(16'sh0000, 1'b0);
    push(16'sh0001, 1'b0);
    push(-16'sh0001, 1'b1);
    push(16'sh5555, 1'b1);
    drain();
    write_reg(mcop_pkg::REG_PAYOFF_MODE, 32'd1);
    push(-16'sh8000, 1'b0);
    push(16'sh2AAA, 1'b0);
    push(16'sh7FFF, 1'b1);
    drain();
    // down-in barrier paths, stray end flag mid path
    write_reg(mcop_pkg::REG_PAYOFF_MODE, 32'd2);
    write_reg(mcop_pkg::REG_STEPS_PER_PATH, 32'd3);
    write_reg(mcop_pkg::REG_BARRIER_LEVEL, -32'sd6710886);
    push(-16'sh1000, 1'b1);
    push(-16'sh1000, 1'b0);
    push(16'sh1000, 1'b0);
    push(16'sh1000, 1'b0);
    push(16'sh1000, 1'b0);
    push(16'sh1000, 1'b1);
    drain();
    // step count lowered mid path
    write_reg(mcop_pkg::REG_PAYOFF_MODE, 32'd3);
    write_reg(mcop_pkg::REG_STEPS_PER_PATH, 32'd8);
    push(-16'sh2000, 1'b0);
    push(-16'sh2000, 1'b0);
    push(16'sh0100, 1'b0);
    drain();
    write_reg(mcop_pkg::REG_STEPS_PER_PATH, 32'd2);
    push(16'sh0100, 1'b1);
    drain();
    // step count zero, then above the cap
    write_reg(mcop_pkg::REG_STEPS_PER_PATH, 32'd0);
    push(16'sh0800, 1'b1);
    drain();
    write_reg(mcop_pkg::REG_STEPS_PER_PATH, 32'd2047);
    write_reg(mcop_pkg::REG_DIFFUSION_STEP, 32'd1677721);
    for (int i = 0; i < STEP_CAP; i++) push(pick_sample(), 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle = idle_sets[p][0];
      recv_stall = idle_sets[p][1];
      for (int sub = 0; sub < 4; sub++) begin
        setup(sub == 1 ? CFG_HIGH : sub == 2 ? CFG_LOW : CFG_TYPICAL);
        if (p == 0 && sub == 0) begin
          write_reg(mcop_pkg::REG_STEPS_PER_PATH, 32'd1);
          hold_req = 1;
        end
        count = (sub == 1 || sub == 2) ? 10 : 28;
        for (int i = 0; i < count; i++) push(pick_sample(), $urandom_range(7, 0) == 0);
        drain();
      end
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
